@@ rtl/averaged_thermostat_relay_unit_macros.svh @@
// assertion macros for the averaged thermostat relay unit
`ifndef AVERAGED_THERMOSTAT_RELAY_UNIT_MACROS_SVH
`define AVERAGED_THERMOSTAT_RELAY_UNIT_MACROS_SVH
`ifndef SYNTH
// checked while reset is low
`define ATR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define ATR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATR_ASSERT(label, clk, rst, prop, msg)
`define ATR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/atr_pkg.sv @@
// shared types and constants of the averaged thermostat relay unit
`timescale 1ns / 1ps
package atr_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int TEMP_W     = 13;
   localparam int SETPOINT_W = 10;
   localparam int BAND_W     = 7;
   localparam int STARTUP_W  = 5;
   localparam int RELEASE_W  = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   // temperature = floor(sum * 1000 / 4100) = floor(sum * 10 / 41)
   // computed as (sum * 10 * ceil(2^26 / 41)) >> 26, exact for sum * 10 < 2^20
   localparam int SCALE_MULT_W = 24;
   localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = 24'd16368020;
   localparam int SCALE_SHIFT = 26;
   localparam logic [TEMP_W-1:0] TEMP_MAX = 13'd8191;

   localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 10'd250;
   localparam logic [BAND_W-1:0]     BAND_RESET     = 7'd10;

   localparam logic [REG_IDX_W-1:0] REG_SETPOINT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BAND     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd2;

   // per-request control carried down the pipeline
   typedef struct packed {
      logic eval;   // relay is evaluated for this request
      logic done;   // startup hold elapsed after this request
   } tick_flags_type;

endpackage

@@ rtl/averaged_thermostat_relay_unit.sv @@
// top level of the averaged thermostat relay unit
`timescale 1ns / 1ps
// pipeline: 3 register stages (sum, scale multiply, relay); last stage drives rsp_valid
// throughput: one request per cycle unless stalled; each stage holds one request
//   and moves on when the stage after it is empty or moving, so stalls only back up as
//   far as needed
// reset (synchronous, active high): history and sum to zero, startup hold reloaded,
//   relay off, registers back to setpoint 250, band 10, relay disabled
`include "averaged_thermostat_relay_unit_macros.svh"
module averaged_thermostat_relay_unit #(
   parameter int WINDOW        = 20,
   parameter int STARTUP_TICKS = 30
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [atr_pkg::SAMPLE_W-1:0]    req_sample,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [atr_pkg::TEMP_W-1:0]      rsp_temperature,
   output logic                            rsp_relay_on,
   output logic                            rsp_startup_done,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [atr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [atr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [atr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import atr_pkg::*;

   localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
   localparam int PROD_W = SUM_W + SCALE_MULT_W;
   localparam int QUOT_W = PROD_W - SCALE_SHIFT;

   // ---------------- register port ----------------
   logic [SETPOINT_W-1:0] setpoint_ff;
   logic [BAND_W-1:0]     band_ff;
   logic                  enable_ff;
   logic                  csr_write;
   logic [REG_IDX_W-1:0]  csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RESET;
         band_ff     <= BAND_RESET;
         enable_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_SETPOINT: setpoint_ff <= pwdata[SETPOINT_W-1:0];
            REG_BAND:     band_ff     <= pwdata[BAND_W-1:0];
            REG_ENABLE:   enable_ff   <= pwdata[0];
            default:      ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SETPOINT: prdata = CSR_DATA_W'(setpoint_ff);
         REG_BAND:     prdata = CSR_DATA_W'(band_ff);
         REG_ENABLE:   prdata = CSR_DATA_W'(enable_ff);
         default:      prdata = '0;
      endcase
   end

   // ---------------- stage flow control ----------------
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;
   logic load2, load3;
   logic req_take;

   assign adv3      = !v3_ff || rsp_ready;
   assign load3     = v2_ff && adv3;
   assign adv2      = !v2_ff || adv3;
   assign load2     = v1_ff && adv2;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign req_take  = req_valid && req_ready;

   // ---------------- stage 1: window sum and startup hold ----------------
   logic [SUM_W-1:0]     window_sum;
   logic [STARTUP_W-1:0] startup_left_ff;
   logic [STARTUP_W-1:0] startup_left_in;
   tick_flags_type       flags1_ff;
   tick_flags_type       flags1_in;

   atr_window #(
      .WINDOW(WINDOW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .push       (req_take),
      .sample     (req_sample),
      .window_sum (window_sum)
   );

   // the request that ends the hold does not evaluate the relay yet
   always_comb begin
      if (startup_left_ff == '0) begin
         startup_left_in = startup_left_ff;
         flags1_in.eval  = 1'b1;
         flags1_in.done  = 1'b1;
      end else begin
         startup_left_in = startup_left_ff - STARTUP_W'(1);
         flags1_in.eval  = 1'b0;
         flags1_in.done  = (startup_left_ff == STARTUP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff           <= 1'b0;
         startup_left_ff <= STARTUP_W'(STARTUP_TICKS);
      end else begin
         if (req_take) begin
            v1_ff           <= 1'b1;
            startup_left_ff <= startup_left_in;
         end else if (adv1) begin
            v1_ff <= 1'b0;
         end
      end
      if (req_take) begin
         flags1_ff <= flags1_in;
      end
   end

   // ---------------- stage 2: scale by reciprocal multiply ----------------
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   tick_flags_type    flags2_ff;

   assign prod_in = PROD_W'(window_sum) * PROD_W'(SCALE_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (load2) begin
         prod_ff   <= prod_in;
         flags2_ff <= flags1_ff;
      end
   end

   // ---------------- stage 3: saturate, hysteresis relay, result ----------------
   logic [QUOT_W-1:0]    quot;
   logic [TEMP_W-1:0]    temp_in;
   logic [RELEASE_W-1:0] release_lvl;
   logic [TEMP_W-1:0]    temp_ff;
   logic                 done_ff;
   logic                 relay_ff;
   logic                 relay_in;

   assign quot = prod_ff[PROD_W-1:SCALE_SHIFT];

   // large windows can overflow the 13-bit reading, so clamp
   always_comb begin
      if (32'(quot) > 32'(TEMP_MAX)) begin
         temp_in = TEMP_MAX;
      end else begin
         temp_in = TEMP_W'(quot);
      end
   end

   // release threshold wraps modulo 2^16 when band exceeds setpoint
   assign release_lvl = RELEASE_W'(setpoint_ff) - RELEASE_W'(band_ff);

   always_comb begin
      relay_in = relay_ff;
      if (flags2_ff.eval) begin
         if (!enable_ff) begin
            relay_in = 1'b0;
         end else if (RELEASE_W'(temp_in) >= RELEASE_W'(setpoint_ff)) begin
            relay_in = 1'b1;
         end else if (RELEASE_W'(temp_in) <= release_lvl) begin
            relay_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff    <= 1'b0;
         relay_ff <= 1'b0;
      end else begin
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (load3) begin
            relay_ff <= relay_in;
         end
      end
      if (load3) begin
         temp_ff <= temp_in;
         done_ff <= flags2_ff.done;
      end
   end

   // relay level only changes when a new result loads, so it is the result bit
   assign rsp_valid        = v3_ff;
   assign rsp_temperature  = temp_ff;
   assign rsp_relay_on     = relay_ff;
   assign rsp_startup_done = done_ff;

   // ---------------- checks ----------------
   `ATR_ASSERT(a_relay_after_hold, clock, reset,
      relay_ff |-> (startup_left_ff == '0), "relay on during startup hold")
   `ATR_ASSERT(a_relay_implies_done, clock, reset,
      (rsp_valid && rsp_relay_on) |-> rsp_startup_done, "relay on before startup done")
   `ATR_ASSERT_ALWAYS(a_reset_clears, clock,
      $past(reset) |-> (!rsp_valid && !v1_ff && !v2_ff &&
         (startup_left_ff == STARTUP_W'(STARTUP_TICKS))), "pipeline not cleared by reset")

endmodule

@@ rtl/atr_window.sv @@
// sample history shift line and running window sum
`timescale 1ns / 1ps
module atr_window #(
   parameter int WINDOW = 20,
   localparam int SUM_W = $clog2(WINDOW * ((1 << atr_pkg::SAMPLE_W) - 1) + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [atr_pkg::SAMPLE_W-1:0]  sample,
   output logic [SUM_W-1:0]              window_sum
);
   import atr_pkg::*;

   logic [SAMPLE_W-1:0] ring_ff [WINDOW];
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;

   // oldest sample drops off the far end
   assign sum_in = sum_ff - SUM_W'(ring_ff[WINDOW-1]) + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (push) begin
         ring_ff[0] <= sample;
         for (int i = 1; i < WINDOW; i++) begin
            ring_ff[i] <= ring_ff[i-1];
         end
         sum_ff <= sum_in;
      end
   end

   assign window_sum = sum_ff;

endmodule
